// ===== rtl/pdd_pkg.sv =====
`default_nettype none

package pdd_pkg;

    localparam int WINDOW    = 10;
    localparam int TIME_BITS = 32;

    localparam int DUTY_FULL = 100;
    localparam int DAC_MAX   = 1023;

    localparam int OP_W   = 2;
    localparam int TS_W   = 32;
    localparam int PCT_W  = 7;
    localparam int DAC_W  = 10;
    localparam int SUM_W  = $clog2(WINDOW * DUTY_FULL + 1);
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PROD_W = TIME_BITS + PCT_W;
    localparam int CNT_W  = $clog2(PCT_W);
    localparam int CODE_PROD_W = PCT_W + DAC_W;

    // sum / WINDOW as a reciprocal multiply, exact for any sum up to WINDOW * 100
    localparam int AVG_SHIFT  = SUM_W + $clog2(WINDOW);
    localparam int AVG_RECIP  = (2 ** AVG_SHIFT + WINDOW - 1) / WINDOW;
    localparam int AVG_PROD_W = SUM_W + AVG_SHIFT + 1;

    // x / 100 as a reciprocal multiply, exact for any x below 2^CODE_PROD_W
    localparam int DAC_SHIFT  = CODE_PROD_W + $clog2(DUTY_FULL);
    localparam int DAC_RECIP  = (2 ** DAC_SHIFT + DUTY_FULL - 1) / DUTY_FULL;
    localparam int DAC_PROD_W = CODE_PROD_W + DAC_SHIFT + 1;

    typedef enum logic [OP_W-1:0] {
        OP_RISE = 2'd0,
        OP_FALL = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_AVG  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic cap_rise;
        logic cap_fall;
        logic div_load;
        logic div_step;
        logic ring_update;
        logic avg_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

    // average percent to DAC code, floor(avg * 1023 / 100), saturated
    function automatic logic [DAC_W-1:0] dac_of(input logic [PCT_W-1:0] avg);
        logic [CODE_PROD_W-1:0] prod;
        logic [DAC_PROD_W-1:0]  scaled;
        logic [CODE_PROD_W-1:0] code;
        prod   = CODE_PROD_W'(avg) * CODE_PROD_W'(DAC_MAX);
        scaled = DAC_PROD_W'(prod) * DAC_PROD_W'(DAC_RECIP);
        code   = CODE_PROD_W'(scaled >> DAC_SHIFT);
        if (code > CODE_PROD_W'(DAC_MAX)) begin
            code = CODE_PROD_W'(DAC_MAX);
        end
        return code[DAC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pdd_ctrl.sv =====
`default_nettype none

module pdd_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [pdd_pkg::OP_W-1:0]  op,
    input  wire pdd_pkg::status_t          status,
    output pdd_pkg::cmd_t                  cmd
);

    pdd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            pdd_pkg::ST_IDLE: begin
                // nothing is taken while reset is held
                s_tready = aresetn;
                if (aresetn && s_tvalid) begin
                    unique case (op)
                        pdd_pkg::OP_RISE: cmd.cap_rise = 1'b1;
                        pdd_pkg::OP_FALL: cmd.cap_fall = 1'b1;
                        pdd_pkg::OP_TICK: begin
                            cmd.div_load = 1'b1;
                            state_next   = pdd_pkg::ST_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            pdd_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = pdd_pkg::ST_SUM;
                end
            end
            pdd_pkg::ST_SUM: begin
                cmd.ring_update = 1'b1;
                state_next      = pdd_pkg::ST_AVG;
            end
            pdd_pkg::ST_AVG: begin
                cmd.avg_load = 1'b1;
                state_next   = pdd_pkg::ST_OUT;
            end
            pdd_pkg::ST_OUT: begin
                // hold until the previous result has left the output register
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = pdd_pkg::ST_IDLE;
                end
            end
            default: state_next = pdd_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pdd_datapath.sv =====
`default_nettype none

module pdd_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [pdd_pkg::TS_W-1:0]      timestamp,
    input  wire pdd_pkg::cmd_t                 cmd,
    output pdd_pkg::status_t                   status,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pdd_pkg::DAC_W-1:0]          dac_code,
    output logic [pdd_pkg::PCT_W-1:0]          duty_percent
);

    localparam int TB  = pdd_pkg::TIME_BITS;
    localparam int PW  = pdd_pkg::PCT_W;
    localparam int SW  = pdd_pkg::SUM_W;
    localparam int QW  = pdd_pkg::PTR_W;
    localparam int PRW = pdd_pkg::PROD_W;
    localparam int CW  = pdd_pkg::CNT_W;
    localparam int AW  = pdd_pkg::AVG_PROD_W;

    logic [TB-1:0] last_rise_reg, high_time_reg, period_reg;
    logic [TB-1:0] rem_reg, rem_next;
    logic [PW-1:0] num_lo_reg, num_lo_next;
    logic [PW-1:0] quot_reg, quot_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          zero_reg, full_reg;
    logic [PW-1:0] duty_reg;
    logic [PW-1:0] ring_reg [pdd_pkg::WINDOW];
    logic [QW-1:0] ptr_reg, ptr_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [PW-1:0] avg_reg;
    logic          m_valid_reg;
    logic [pdd_pkg::DAC_W-1:0] code_reg;
    logic [PW-1:0] out_duty_reg;

    logic [TB-1:0]  ts;
    logic [PRW-1:0] prod;
    logic [TB:0]    trial;
    logic           ge;
    logic [PW-1:0]  duty;
    logic [AW-1:0]  avg_prod;

    assign ts    = timestamp[TB-1:0];
    assign prod  = PRW'(high_time_reg) * PRW'(pdd_pkg::DUTY_FULL);
    assign trial = {rem_reg, num_lo_reg[PW-1]};
    assign ge    = (trial >= {1'b0, period_reg});

    // restoring division, one quotient bit per cycle; quotient < 128 unless clamped
    always_comb begin
        rem_next    = rem_reg;
        num_lo_next = num_lo_reg;
        quot_next   = quot_reg;
        cnt_next    = cnt_reg;
        if (cmd.div_load) begin
            rem_next    = prod[PRW-1:PW];
            num_lo_next = prod[PW-1:0];
            quot_next   = '0;
            cnt_next    = '0;
        end else if (cmd.div_step) begin
            rem_next    = ge ? TB'(trial - {1'b0, period_reg}) : trial[TB-1:0];
            num_lo_next = {num_lo_reg[PW-2:0], 1'b0};
            quot_next   = {quot_reg[PW-2:0], ge};
            cnt_next    = cnt_reg + CW'(1);
        end
    end

    assign status.div_last = (cnt_reg == CW'(PW - 1));
    assign status.out_free = !m_valid_reg || m_tready;

    always_comb begin
        if (zero_reg) begin
            duty = '0;
        end else if (full_reg) begin
            duty = PW'(pdd_pkg::DUTY_FULL);
        end else begin
            duty = quot_reg;
        end
    end

    assign sum_next = sum_reg - SW'(ring_reg[ptr_reg]) + SW'(duty);
    assign ptr_next = (ptr_reg == QW'(pdd_pkg::WINDOW - 1)) ? '0 : ptr_reg + QW'(1);

    // window average through the reciprocal of WINDOW
    assign avg_prod = AW'(sum_reg) * AW'(pdd_pkg::AVG_RECIP);

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        num_lo_reg <= num_lo_next;
        quot_reg   <= quot_next;
        if (cmd.div_load) begin
            zero_reg <= (period_reg == '0);
            full_reg <= (high_time_reg >= period_reg);
        end
        if (cmd.ring_update) begin
            duty_reg <= duty;
        end
        if (cmd.avg_load) begin
            avg_reg <= PW'(avg_prod >> pdd_pkg::AVG_SHIFT);
        end
        if (cmd.out_load) begin
            code_reg     <= pdd_pkg::dac_of(avg_reg);
            out_duty_reg <= duty_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_rise_reg <= '0;
            high_time_reg <= '0;
            period_reg    <= '0;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < pdd_pkg::WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.cap_rise) begin
                period_reg    <= ts - last_rise_reg;
                last_rise_reg <= ts;
            end
            if (cmd.cap_fall) begin
                high_time_reg <= ts - last_rise_reg;
            end
            if (cmd.ring_update) begin
                ring_reg[ptr_reg] <= duty;
                sum_reg           <= sum_next;
                ptr_reg           <= ptr_next;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign dac_code     = code_reg;
    assign duty_percent = out_duty_reg;

`ifndef SYNTHESIS
    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= SW'(pdd_pkg::WINDOW * pdd_pkg::DUTY_FULL))
        else $error("window sum out of range");
    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= QW'(pdd_pkg::WINDOW - 1))
        else $error("ring pointer out of range");
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg && (out_duty_reg == $past(duty_reg)))
        else $error("result not presented after load");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("pending result overwritten");
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ring_update |-> (duty <= PW'(pdd_pkg::DUTY_FULL)))
        else $error("duty above full scale");
`endif

endmodule

`default_nettype wire

// ===== rtl/pwm_duty_demodulator.sv =====
`default_nettype none

// PWM duty demodulator. Each input transaction carries an op in s_tuser and a
// timer capture in s_tdata. Rising and falling edge captures give no result.
// An update tick computes duty = high_time * 100 / period (clamped to 100, 0
// for a zero period) on a restoring divider that yields one quotient bit per
// cycle, pushes it into a 10-entry moving-average ring and emits one result
// transaction: the averaged duty scaled to a 10-bit DAC code plus this tick's
// duty. A tick occupies the block through the divider, ring sum, average and
// output states, longer if the previous result has not yet been taken from the
// output register. Op value 3 is accepted and ignored.
module pwm_duty_demodulator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] timestamp
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [9:0] dac_code, [16:10] duty_percent, rest zero
);

    pdd_pkg::cmd_t    cmd;
    pdd_pkg::status_t status;

    logic [pdd_pkg::DAC_W-1:0] dac_code;
    logic [pdd_pkg::PCT_W-1:0] duty_percent;

    pdd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    pdd_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .timestamp    (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .dac_code     (dac_code),
        .duty_percent (duty_percent)
    );

    assign m_tdata = {7'd0, duty_percent, dac_code};

endmodule

`default_nettype wire
